[rtl/core/tcce_pkg.sv]
// ----------------------------------------------------------------------------
// tcce_pkg
// shared types and constants of the text console cursor engine
// ----------------------------------------------------------------------------
package tcce_pkg;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CHAR_W = 8;
  localparam int IDX_W  = 11;
  localparam int CELL_W = 16;
  localparam int CMD_W  = 2;

  localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;
  localparam logic [CHAR_W-1:0] CH_NUL       = 8'd0;
  localparam logic [CHAR_W-1:0] RESET_ATTR   = 8'd7;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_NL,
    ST_CLEAR,
    ST_SCROLL,
    ST_DRAIN,
    ST_ZERO,
    ST_DONE
  } state_t;

  // controls for the shared address sweep unit
  typedef struct packed {
    logic load;
    logic step;
  } sweep_ctl_t;

  // sequencer status toward the top level
  typedef struct packed {
    logic idle;
    logic res_valid;
    logic rd_hit;
  } ctrl_stat_t;

endpackage

[rtl/core/tcce_cell_ram.sv]
// ----------------------------------------------------------------------------
// tcce_cell_ram
// screen cell store, one write port and one registered read port
// ----------------------------------------------------------------------------
module tcce_cell_ram #(
  parameter int DEPTH  = 2000,
  parameter int ADDR_W = 11
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [ADDR_W-1:0]           wr_addr,
  input  logic [tcce_pkg::CELL_W-1:0] wr_data,
  input  logic                        rd_en,
  input  logic [ADDR_W-1:0]           rd_addr,
  output logic [tcce_pkg::CELL_W-1:0] rd_data
);
  import tcce_pkg::*;

  logic [CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/core/tcce_sweep.sv]
// ----------------------------------------------------------------------------
// tcce_sweep
// shared address counter with end compare, used by every multi-cycle walk
// ----------------------------------------------------------------------------
module tcce_sweep #(
  parameter int ADDR_W = 11,
  parameter int CELLS  = 2000
) (
  input  logic                   clk,
  input  logic                   rst,
  input  tcce_pkg::sweep_ctl_t   ctl,
  input  logic [ADDR_W-1:0]      start,
  input  logic [ADDR_W-1:0]      stop,
  output logic [ADDR_W-1:0]      ptr,
  output logic                   last
);
  import tcce_pkg::*;

  logic [ADDR_W-1:0] stop_q;

  // reset leaves the unit set up for the power-on clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr    <= '0;
      stop_q <= ADDR_W'(CELLS - 1);
    end else if (ctl.load) begin
      ptr    <= start;
      stop_q <= stop;
    end else if (ctl.step) begin
      ptr <= ptr + 1'b1;
    end
  end

  assign last = (ptr == stop_q);

endmodule

[rtl/core/tcce_ctrl.sv]
// ----------------------------------------------------------------------------
// tcce_ctrl
// command sequencer: cursor, cell writes, row walks, scroll copy, clear
// ----------------------------------------------------------------------------
module tcce_ctrl #(
  parameter int COLUMNS_PER_ROW = 80,
  parameter int ROWS_ON_SCREEN  = 25,
  parameter int CELLS           = 2000,
  parameter int ADDR_W          = 11
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [tcce_pkg::CMD_W-1:0]  cmd,
  input  logic [tcce_pkg::CHAR_W-1:0] char_code,
  input  logic [tcce_pkg::IDX_W-1:0]  cell_index,
  input  logic [tcce_pkg::CHAR_W-1:0] attr,
  input  logic                        res_take,
  input  logic [tcce_pkg::CELL_W-1:0] rd_data,
  input  logic [ADDR_W-1:0]           ptr,
  input  logic                        last,
  output tcce_pkg::sweep_ctl_t        sweep_ctl,
  output logic [ADDR_W-1:0]           sweep_start,
  output logic [ADDR_W-1:0]           sweep_stop,
  output logic                        wr_en,
  output logic [ADDR_W-1:0]           wr_addr,
  output logic [tcce_pkg::CELL_W-1:0] wr_data,
  output logic                        rd_en,
  output logic [ADDR_W-1:0]           rd_addr,
  output logic [tcce_pkg::COL_W-1:0]  col,
  output logic [tcce_pkg::ROW_W-1:0]  row,
  output tcce_pkg::ctrl_stat_t        stat
);
  import tcce_pkg::*;

  localparam logic [COL_W-1:0]  COL_MAX   = COL_W'(COLUMNS_PER_ROW - 1);
  localparam logic [ROW_W-1:0]  ROW_MAX   = ROW_W'(ROWS_ON_SCREEN - 1);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] ROW1_ADDR = ADDR_W'(COLUMNS_PER_ROW);
  localparam logic [ADDR_W-1:0] BOT_ADDR  = ADDR_W'(CELLS - COLUMNS_PER_ROW);

  state_t            state, state_next;
  logic [COL_W-1:0]  col_next;
  logic [ROW_W-1:0]  row_next;
  logic              scroll_pend;
  logic              rd_hit;
  logic              cp_wr;
  logic [ADDR_W-1:0] cp_addr;

  logic              is_put, is_nl, is_bs, is_chr, is_read, idx_ok;
  logic              at_last_col, at_last_row;
  logic [COL_W-1:0]  bs_col, addr_col;
  logic [ROW_W-1:0]  bs_row, addr_row, row_adv;
  logic [ADDR_W-1:0] acc_addr, row_end;
  logic              chr_scroll;

  // command decode and cursor arithmetic
  always_comb begin
    is_put      = (cmd == CMD_PUT);
    is_nl       = is_put && (char_code == CH_NEWLINE);
    is_bs       = is_put && (char_code == CH_BACKSPACE);
    is_chr      = is_put && !is_nl && !is_bs;
    is_read     = (cmd == CMD_READ);
    idx_ok      = (32'(cell_index) < CELLS);
    at_last_col = (col == COL_MAX);
    at_last_row = (row == ROW_MAX);
    row_adv     = at_last_row ? row : row + 1'b1;
    chr_scroll  = at_last_col && at_last_row;
    if (col == '0 && row == '0) begin
      bs_col = col;
      bs_row = row;
    end else if (col == '0) begin
      bs_col = COL_MAX;
      bs_row = row - 1'b1;
    end else begin
      bs_col = col - 1'b1;
      bs_row = row;
    end
    addr_col = is_bs ? bs_col : col;
    addr_row = is_bs ? bs_row : row;
    acc_addr = ADDR_W'(32'(addr_row) * COLUMNS_PER_ROW + 32'(addr_col));
    row_end  = ADDR_W'(32'(row) * COLUMNS_PER_ROW + COLUMNS_PER_ROW - 1);
  end

  always_comb begin
    col_next = col;
    row_next = row;
    if (accept) begin
      case (cmd)
        CMD_PUT: begin
          if (is_nl) begin
            col_next = '0;
            row_next = row_adv;
          end else if (is_bs) begin
            col_next = bs_col;
            row_next = bs_row;
          end else if (at_last_col) begin
            col_next = '0;
            row_next = row_adv;
          end else begin
            col_next = col + 1'b1;
          end
        end
        CMD_CLEAR: begin
          col_next = '0;
          row_next = '0;
        end
        default: begin
          col_next = col;
          row_next = row;
        end
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_INIT:   if (last) state_next = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          if (is_nl) begin
            state_next = ST_NL;
          end else if (is_chr && chr_scroll) begin
            state_next = ST_SCROLL;
          end else if (cmd == CMD_CLEAR) begin
            state_next = ST_CLEAR;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_NL:     if (last) state_next = scroll_pend ? ST_SCROLL : ST_DONE;
      ST_CLEAR:  if (last) state_next = ST_DONE;
      ST_SCROLL: if (last) state_next = ST_DRAIN;
      ST_DRAIN:  state_next = ST_ZERO;
      ST_ZERO:   if (last) state_next = ST_DONE;
      ST_DONE:   if (res_take) state_next = ST_IDLE;
      default:   state_next = ST_INIT;
    endcase
  end

  // memory port, sweep and status controls
  always_comb begin
    sweep_ctl   = '0;
    sweep_start = '0;
    sweep_stop  = LAST_ADDR;
    wr_en       = 1'b0;
    wr_addr     = ptr;
    wr_data     = '0;
    rd_en       = 1'b0;
    rd_addr     = ptr;
    stat.idle      = (state == ST_IDLE);
    stat.res_valid = (state == ST_DONE);
    stat.rd_hit    = rd_hit;
    case (state)
      ST_INIT: begin
        sweep_ctl.step = 1'b1;
        wr_en   = 1'b1;
        wr_data = {RESET_ATTR, CH_NUL};
      end
      ST_IDLE: begin
        if (accept) begin
          if (is_put && !is_nl) begin
            wr_en   = 1'b1;
            wr_addr = acc_addr;
            wr_data = {attr, is_bs ? CH_SPACE : char_code};
          end
          if (is_nl) begin
            sweep_ctl.load = 1'b1;
            sweep_start    = acc_addr;
            sweep_stop     = row_end;
          end else if (is_chr && chr_scroll) begin
            sweep_ctl.load = 1'b1;
            sweep_start    = ROW1_ADDR;
          end else if (cmd == CMD_CLEAR) begin
            sweep_ctl.load = 1'b1;
          end
          if (is_read && idx_ok) begin
            rd_en   = 1'b1;
            rd_addr = ADDR_W'(cell_index);
          end
        end
      end
      ST_NL: begin
        sweep_ctl.step = 1'b1;
        wr_en   = 1'b1;
        wr_data = {attr, CH_SPACE};
        if (last && scroll_pend) begin
          sweep_ctl.load = 1'b1;
          sweep_start    = ROW1_ADDR;
        end
      end
      ST_CLEAR: begin
        sweep_ctl.step = 1'b1;
        wr_en   = 1'b1;
        wr_data = {attr, CH_NUL};
      end
      ST_SCROLL: begin
        sweep_ctl.step = 1'b1;
        rd_en = 1'b1;
      end
      ST_DRAIN: begin
        sweep_ctl.load = 1'b1;
        sweep_start    = BOT_ADDR;
      end
      ST_ZERO: begin
        sweep_ctl.step = 1'b1;
        wr_en   = 1'b1;
        wr_data = '0;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
    // copy write of the scroll, in the cycle after its read
    if (cp_wr) begin
      wr_en   = 1'b1;
      wr_addr = cp_addr;
      wr_data = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_INIT;
      col         <= '0;
      row         <= '0;
      scroll_pend <= 1'b0;
      rd_hit      <= 1'b0;
      cp_wr       <= 1'b0;
    end else begin
      state <= state_next;
      col   <= col_next;
      row   <= row_next;
      cp_wr <= (state == ST_SCROLL);
      if (accept) begin
        scroll_pend <= is_nl && at_last_row;
        rd_hit      <= is_read && idx_ok;
      end
    end
  end

  always_ff @(posedge clk) begin
    cp_addr <= ptr - ROW1_ADDR;
  end

endmodule

[rtl/core/text_console_cursor_engine_top.sv]
// ----------------------------------------------------------------------------
// text_console_cursor_engine_top
// character-cell text console with cursor, scroll, clear and cell read
// ----------------------------------------------------------------------------
// usage
//   req channel (req_valid/req_stall) takes one command item: cmd, char_code,
//   cell_index. rsp channel (rsp_valid/rsp_stall) returns one item per
//   command: cursor after the command and, for a read, the cell contents.
//   cfg channel (cfg_valid/cfg_ready) writes the text attribute; write it
//   only while no command is in flight.
// work per command, up to the result register load
//   put char, backspace, read, unused code: at most one cell write or read
//   newline: a walk that fills the rest of the row with spaces
//   clear: a walk that writes char 0 to every cell
//   a scroll off the bottom adds a row copy walk, then a bottom fill walk
// throughput: the next command is taken once the sequencer is back in idle,
//   in the cycle after the result loads
// the walks are set by the single-port-write cell store and the one shared
// address counter that walks it; one command is worked on at a time
// reset: the store is swept to char 0 with attribute 7, one cell a cycle,
//   with req_stall high meanwhile
// a stalled rsp item holds; the next command is still taken and its result
//   waits in the sequencer until the output register frees up
// ----------------------------------------------------------------------------
module text_console_cursor_engine_top #(
  parameter int COLUMNS_PER_ROW = 80,
  parameter int ROWS_ON_SCREEN  = 25
) (
  input  logic                        clk,
  input  logic                        rst,
  // command items
  input  logic                        req_valid,
  output logic                        req_stall,
  input  logic [tcce_pkg::CMD_W-1:0]  cmd,
  input  logic [tcce_pkg::CHAR_W-1:0] char_code,
  input  logic [tcce_pkg::IDX_W-1:0]  cell_index,
  // result items
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output logic [tcce_pkg::COL_W-1:0]  cursor_x,
  output logic [tcce_pkg::ROW_W-1:0]  cursor_y,
  output logic [tcce_pkg::CHAR_W-1:0] cell_char,
  output logic [tcce_pkg::CHAR_W-1:0] cell_attr,
  // attribute register write
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [tcce_pkg::CHAR_W-1:0] cfg_data
);
  import tcce_pkg::*;

  localparam int CELLS  = COLUMNS_PER_ROW * ROWS_ON_SCREEN;
  localparam int ADDR_W = $clog2(CELLS);

  logic [CHAR_W-1:0] text_attribute;
  logic              accept;
  logic              res_take;
  ctrl_stat_t        stat;
  sweep_ctl_t        sweep_ctl;
  logic [ADDR_W-1:0] sweep_start, sweep_stop, ptr;
  logic              last;
  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [CELL_W-1:0] wr_data, rd_data;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;

  // attribute register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_attribute <= RESET_ATTR;
    end else if (cfg_valid && cfg_ready) begin
      text_attribute <= cfg_data;
    end
  end

  // commands enter only when the sequencer sits idle
  assign req_stall = !stat.idle;
  assign accept    = req_valid && !req_stall;

  // finished result moves into the output register when it is free or leaving
  assign res_take = stat.res_valid && (!rsp_valid || !rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_take) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      cursor_x  <= col;
      cursor_y  <= row;
      cell_char <= stat.rd_hit ? rd_data[CHAR_W-1:0] : CH_NUL;
      cell_attr <= stat.rd_hit ? rd_data[CELL_W-1:CHAR_W] : CH_NUL;
    end
  end

  tcce_ctrl #(
    .COLUMNS_PER_ROW (COLUMNS_PER_ROW),
    .ROWS_ON_SCREEN  (ROWS_ON_SCREEN),
    .CELLS           (CELLS),
    .ADDR_W          (ADDR_W)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .cmd         (cmd),
    .char_code   (char_code),
    .cell_index  (cell_index),
    .attr        (text_attribute),
    .res_take    (res_take),
    .rd_data     (rd_data),
    .ptr         (ptr),
    .last        (last),
    .sweep_ctl   (sweep_ctl),
    .sweep_start (sweep_start),
    .sweep_stop  (sweep_stop),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .col         (col),
    .row         (row),
    .stat        (stat)
  );

  tcce_sweep #(
    .ADDR_W (ADDR_W),
    .CELLS  (CELLS)
  ) u_sweep (
    .clk   (clk),
    .rst   (rst),
    .ctl   (sweep_ctl),
    .start (sweep_start),
    .stop  (sweep_stop),
    .ptr   (ptr),
    .last  (last)
  );

  tcce_cell_ram #(
    .DEPTH  (CELLS),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // reset starts the clearing pass, so no command may enter right after it
  a_reset_stalls: assert property (@(posedge clk) rst |=> req_stall)
    else $error("command taken during reset clearing pass");

  // one command at a time: the cycle after an accept is always busy
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    accept |=> req_stall)
    else $error("second command taken while one is in flight");

  // reported cursor stays on the screen
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (32'(cursor_x) < COLUMNS_PER_ROW) && (32'(cursor_y) < ROWS_ON_SCREEN))
    else $error("cursor reported off screen");

endmodule
